FILE: src/lzd_pkg.sv
// ----------------------------------------------------------------------------
// LZ block decompressor package
// Shared widths, limits and the parser phase type.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned SizeW      = 19;
  localparam int unsigned LenW       = 5;
  localparam int unsigned OffW       = 16;
  localparam int unsigned TokW       = 3;
  localparam int unsigned BlockLimit = 262144;

  typedef enum logic [2:0] {
    PhCtrl,
    PhLen,
    PhLit,
    PhOffLo,
    PhOffHi,
    PhCopy,
    PhDone
  } phase_e;

  // Length of a token: high nibble for the first of a pair, low for the second
  function automatic logic [LenW-1:0] tok_len(input logic [ByteW-1:0] len_pair,
                                              input logic [TokW-1:0] tok);
    logic [3:0] nib;
    nib = tok[0] ? len_pair[3:0] : len_pair[7:4];
    return {1'b0, nib} + LenW'(1);
  endfunction

  // Flags are MSB first: token t uses bit 7-t
  function automatic phase_e tok_phase(input logic [ByteW-1:0] flags,
                                       input logic [TokW-1:0] tok);
    return flags[~tok] ? PhOffLo : PhLit;
  endfunction

endpackage

FILE: src/lzd_if.sv
// ----------------------------------------------------------------------------
// LZ block decompressor stream interfaces
// Compressed byte channel and decompressed byte channel, valid/ready.
// ----------------------------------------------------------------------------
interface lzd_in_if;
  import lzd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

interface lzd_out_if;
  import lzd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             block_done;
  logic             ref_error;

  modport source (output valid, output out_byte, output run_last, output block_done,
                  output ref_error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input block_done,
                  input ref_error, output ready);
endinterface

FILE: src/lz_block_decompressor.sv
// ----------------------------------------------------------------------------
// LZ block decompressor
// Byte-oriented LZ77 decoder with a history memory of WINDOW_DEPTH bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries compressed bytes; block_start set on a byte restarts the
//   parser and makes that byte the first control byte of a new block.
//   out_o carries decompressed bytes; run_last marks the last byte caused by
//   one input transaction, block_done the byte that completes output_size
//   or an error, ref_error a match reaching before the block or onto itself.
//   cfg_we_i/cfg_wdata_i write output_size; write it only while idle.
// Timing:
//   Control, length, offset and literal bytes each take one input
//   transaction. The offset high byte of a match starts a copy out of the
//   history memory: a registered read, then one byte per cycle while out_o
//   does not stall; in_i is held off until the match is copied. A literal
//   byte is registered into out_o in the cycle after its transaction.
// Reset and stall:
//   Reset empties the output register and sets the parser to await a
//   control byte with output_size 0; the history needs no clearing.
//   When out_o stalls, the output register holds, the copy pauses and
//   in_i is held off until the output register can take a byte again.
// ----------------------------------------------------------------------------
module lz_block_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 131072
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lzd_in_if.sink                    in_i,
  lzd_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [lzd_pkg::SizeW-1:0] cfg_wdata_i
);
  import lzd_pkg::*;

  localparam int unsigned AddrW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned AddrW1 = AddrW + 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WINDOW_DEPTH - 1);
  localparam logic [AddrW-1:0] WinWrap  = AddrW'(WINDOW_DEPTH);

  // Parser state
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  flags_q, flags_d;
  logic [TokW-1:0]   tok_q, tok_d;
  logic [ByteW-1:0]  len_q, len_d;
  logic [SizeW-1:0]  pair_base_q, pair_base_d;
  logic [AddrW-1:0]  pair_ptr_q, pair_ptr_d;
  logic [LenW-1:0]   left_q, left_d;
  logic [ByteW-1:0]  offlo_q, offlo_d;
  logic [SizeW-1:0]  count_q, count_d;
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  src_ptr_q, src_ptr_d;
  logic              rd_valid_q, rd_valid_d;
  logic [SizeW-1:0]  size_q;

  // History memory and forwarding
  logic [ByteW-1:0]  hist_mem [WINDOW_DEPTH];
  logic [ByteW-1:0]  rd_q;
  logic              fwd_q;
  logic [ByteW-1:0]  fwd_data_q;
  logic              rd_en;
  logic              wr_en;
  logic [ByteW-1:0]  wr_data;
  logic [ByteW-1:0]  copy_byte;

  // Output register
  logic              out_valid_q;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_last_q;
  logic              out_done_q;
  logic              out_err_q;

  logic              emit;
  logic [ByteW-1:0]  emit_byte;
  logic              emit_last;
  logic              emit_done;
  logic              emit_err;

  logic              slot_free;
  logic              in_acc;
  logic              fin;
  phase_e            eff_phase;
  logic [SizeW-1:0]  eff_count;
  logic [SizeW-1:0]  count_inc;
  logic              reach_size;
  logic [AddrW-1:0]  wr_inc;
  logic [AddrW-1:0]  src_inc;
  logic [OffW-1:0]   off;
  logic [SizeW-1:0]  off_ext;
  logic              bad_ref;
  logic [AddrW:0]    src_diff;
  logic [AddrW-1:0]  src_start;
  logic [TokW-1:0]   tok_next;
  logic              too_big;

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = slot_free && (phase_q != PhCopy);
  assign in_acc     = in_i.valid && in_i.ready;

  assign count_inc  = count_q + SizeW'(1);
  assign reach_size = count_inc >= size_q;
  assign wr_inc     = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
  assign src_inc    = (src_ptr_q == LastAddr) ? '0 : src_ptr_q + AddrW'(1);
  assign too_big    = 32'(size_q) > BlockLimit;

  assign off       = {in_i.data_byte, offlo_q};
  assign off_ext   = SizeW'(off);
  assign bad_ref   = (off_ext > pair_base_q) || ((pair_base_q - off_ext) >= count_q);
  assign src_diff  = {1'b0, pair_ptr_q} - AddrW1'(off);
  // Wrap a negative source back into the window
  assign src_start = src_diff[AddrW] ? src_diff[AddrW-1:0] + WinWrap : src_diff[AddrW-1:0];

  assign copy_byte = fwd_q ? fwd_data_q : rd_q;
  assign tok_next  = tok_q + TokW'(1);

  always_comb begin
    phase_d     = phase_q;
    flags_d     = flags_q;
    tok_d       = tok_q;
    len_d       = len_q;
    pair_base_d = pair_base_q;
    pair_ptr_d  = pair_ptr_q;
    left_d      = left_q;
    offlo_d     = offlo_q;
    count_d     = count_q;
    wr_ptr_d    = wr_ptr_q;
    src_ptr_d   = src_ptr_q;
    rd_valid_d  = rd_valid_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = in_i.data_byte;
    emit        = 1'b0;
    emit_byte   = in_i.data_byte;
    emit_last   = 1'b1;
    emit_done   = 1'b0;
    emit_err    = 1'b0;
    fin         = 1'b0;
    eff_phase   = in_i.block_start ? PhCtrl : phase_q;
    eff_count   = in_i.block_start ? '0 : count_q;

    if (in_acc) begin
      if (in_i.block_start) begin
        phase_d     = PhCtrl;
        flags_d     = '0;
        tok_d       = '0;
        len_d       = '0;
        pair_base_d = '0;
        pair_ptr_d  = '0;
        left_d      = '0;
        offlo_d     = '0;
        count_d     = '0;
        wr_ptr_d    = '0;
      end
      if (eff_phase == PhDone) begin
        // drop the byte
      end else if (too_big || (eff_count >= size_q)) begin
        phase_d = PhDone;
      end else begin
        case (eff_phase)
          PhCtrl: begin
            flags_d = in_i.data_byte;
            tok_d   = '0;
            phase_d = PhLen;
          end
          PhLen: begin
            len_d       = in_i.data_byte;
            pair_base_d = count_q;
            pair_ptr_d  = wr_ptr_q;
            left_d      = tok_len(in_i.data_byte, tok_q);
            phase_d     = tok_phase(flags_q, tok_q);
          end
          PhLit: begin
            wr_en     = 1'b1;
            count_d   = count_inc;
            wr_ptr_d  = wr_inc;
            emit      = 1'b1;
            emit_done = reach_size;
            left_d    = left_q - LenW'(1);
            if (reach_size) begin
              phase_d = PhDone;
            end else if (left_q == LenW'(1)) begin
              fin = 1'b1;
            end
          end
          PhOffLo: begin
            offlo_d = in_i.data_byte;
            phase_d = PhOffHi;
          end
          PhOffHi: begin
            if (bad_ref) begin
              emit      = 1'b1;
              emit_byte = '0;
              emit_done = 1'b1;
              emit_err  = 1'b1;
              phase_d   = PhDone;
            end else begin
              src_ptr_d  = src_start;
              rd_valid_d = 1'b0;
              phase_d    = PhCopy;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (phase_q == PhCopy) begin
      if (!rd_valid_q) begin
        rd_en      = 1'b1;
        rd_valid_d = 1'b1;
        src_ptr_d  = src_inc;
      end else if (slot_free) begin
        wr_en     = 1'b1;
        wr_data   = copy_byte;
        count_d   = count_inc;
        wr_ptr_d  = wr_inc;
        emit      = 1'b1;
        emit_byte = copy_byte;
        emit_done = reach_size;
        emit_last = reach_size || (left_q == LenW'(1));
        left_d    = left_q - LenW'(1);
        if (reach_size) begin
          phase_d    = PhDone;
          rd_valid_d = 1'b0;
        end else if (left_q == LenW'(1)) begin
          fin        = 1'b1;
          rd_valid_d = 1'b0;
        end else begin
          rd_en     = 1'b1;
          src_ptr_d = src_inc;
        end
      end
    end

    // Advance to the next token of the pair, to the next pair, or to the next control byte
    if (fin) begin
      tok_d = tok_next;
      if (!tok_q[0]) begin
        left_d  = tok_len(len_q, tok_next);
        phase_d = tok_phase(flags_q, tok_next);
      end else if (tok_next == '0) begin
        phase_d = PhCtrl;
      end else begin
        phase_d = PhLen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhCtrl;
      flags_q     <= '0;
      tok_q       <= '0;
      len_q       <= '0;
      pair_base_q <= '0;
      pair_ptr_q  <= '0;
      left_q      <= '0;
      offlo_q     <= '0;
      count_q     <= '0;
      wr_ptr_q    <= '0;
      src_ptr_q   <= '0;
      rd_valid_q  <= 1'b0;
      size_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      flags_q     <= flags_d;
      tok_q       <= tok_d;
      len_q       <= len_d;
      pair_base_q <= pair_base_d;
      pair_ptr_q  <= pair_ptr_d;
      left_q      <= left_d;
      offlo_q     <= offlo_d;
      count_q     <= count_d;
      wr_ptr_q    <= wr_ptr_d;
      src_ptr_q   <= src_ptr_d;
      rd_valid_q  <= rd_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_ptr_q] <= wr_data;
    end
  end

  // A read of the entry written at the same edge takes the new byte
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q       <= hist_mem[src_ptr_q];
      fwd_q      <= wr_en && (wr_ptr_q == src_ptr_q);
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
      out_done_q <= emit_done;
      out_err_q  <= emit_err;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.run_last   = out_last_q;
  assign out_o.block_done = out_done_q;
  assign out_o.ref_error  = out_err_q;

`ifndef SYNTHESIS
  a_err_ends_block : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ref_error |-> out_o.block_done && out_o.run_last)
    else $error("reference error without block end");

  a_done_parks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_done |=> phase_q == PhDone)
    else $error("parser not done after final byte");

  a_emit_in_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !emit_err |-> count_q < size_q)
    else $error("byte emitted beyond output size");

  a_read_in_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> phase_q == PhCopy)
    else $error("history read pending outside copy");
`endif

endmodule

FILE: tb/lz_block_decompressor_tb.sv
// ----------------------------------------------------------------------------
// LZ block decompressor testbench
// Feeds compressed blocks through the valid/ready input channel and checks
// every decompressed byte against a behavioural decoder in the bench or the
// result in a typed row. A short table of hand-written rows comes first, then
// random blocks with random output sizes, flags, lengths and offsets, and
// some noise. Both channels idle at random, save in calm stretches.
// ----------------------------------------------------------------------------
module lz_block_decompressor_tb;
  import lzd_pkg::*;

  localparam int unsigned WinDepth  = 131072;
  localparam int unsigned NumRand   = 250;
  localparam int unsigned Settle    = 40;
  localparam int unsigned MaxReport = 10;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             block_done;
    logic             ref_error;
  } lz_out_t;

  typedef enum logic {
    RowCfg,
    RowByte
  } row_kind_e;

  // typed rows carry their single result here; n_res 0 means none at all
  typedef struct packed {
    row_kind_e        kind;
    logic [SizeW-1:0] value;
    logic             start;
    logic             typed;
    logic             n_res;
    logic [ByteW-1:0] e_byte;
    logic             e_done;
    logic             e_err;
  } stim_row_t;

  localparam int unsigned NumDir = 33;
  localparam stim_row_t DirTab [NumDir] = '{
    // parse from the reset state, no block start yet
    '{RowCfg,  19'd40,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h12,     1'b0, 1'b1, 1'b1, 8'h12, 1'b0, 1'b0},
    // zero output size: nothing decoded, later bytes ignored
    '{RowCfg,  19'd0,      1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h55,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // size above the block limit
    '{RowCfg,  19'h7FFFF,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'hFF,     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // literal, match of offset zero on the second token, then a match
    // reaching before the block start
    '{RowCfg,  19'd40,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h50,     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'hFF,     1'b0, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h13,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h80,     1'b0, 1'b1, 1'b1, 8'h80, 1'b0, 1'b0},
    '{RowByte, 19'h03,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
    '{RowByte, 19'h77,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    // largest legal size; a first-token match onto its own destination
    '{RowCfg,  19'd262144, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h80,     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'hF0,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
    // overlapping match cut short by the output size
    '{RowCfg,  19'd3,      1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h40,     1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h1F,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'hAA,     1'b0, 1'b1, 1'b1, 8'hAA, 1'b0, 1'b0},
    '{RowByte, 19'h55,     1'b0, 1'b1, 1'b1, 8'h55, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{RowByte, 19'h00,     1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [SizeW-1:0] cfg_wdata;

  lzd_in_if  in_bus ();
  lzd_out_if out_bus ();

  lz_block_decompressor #(
    .WINDOW_DEPTH (WinDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Decoder state kept by the bench
  logic [ByteW-1:0] hist_mem [WinDepth];
  phase_e           ph_q;
  logic [ByteW-1:0] flags_q;
  logic [ByteW-1:0] lens_q;
  logic [ByteW-1:0] off_lo_q;
  logic [TokW-1:0]  tok_q;
  logic [LenW-1:0]  left_q;
  logic [SizeW-1:0] base_q;
  logic [SizeW-1:0] cnt_q;
  logic [SizeW-1:0] size_q;

  lz_out_t step_bytes [$];
  lz_out_t decoded_q [$];

  bit          calm;
  int unsigned mism;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned n_done;
  int unsigned n_err;
  int unsigned n_sizes;

  function automatic logic [LenW-1:0] token_bytes();
    logic [3:0] nib;
    if (tok_q[0]) begin
      nib = lens_q[3:0];
    end else begin
      nib = lens_q[7:4];
    end
    return LenW'(nib) + LenW'(1);
  endfunction

  function automatic void open_token();
    left_q = token_bytes();
    ph_q = flags_q[3'd7 - tok_q] ? PhOffLo : PhLit;
  endfunction

  function automatic void close_token();
    logic second;
    second = tok_q[0];
    tok_q = tok_q + TokW'(1);
    if (!second) begin
      open_token();
    end else if (tok_q == '0) begin
      ph_q = PhCtrl;
    end else begin
      ph_q = PhLen;
    end
  endfunction

  // Write one byte to the history and queue it; returns 1 at the block end
  function automatic logic store_byte(input logic [ByteW-1:0] b);
    lz_out_t r;
    logic fin;
    hist_mem[cnt_q % WinDepth] = b;
    cnt_q = cnt_q + SizeW'(1);
    fin = (cnt_q >= size_q);
    r = '{out_byte: b, run_last: 1'b0, block_done: fin, ref_error: 1'b0};
    step_bytes.push_back(r);
    if (fin) begin
      ph_q = PhDone;
    end
    return fin;
  endfunction

  function automatic void decode_byte(input logic [ByteW-1:0] d, input logic s);
    logic [OffW-1:0]  off;
    logic [SizeW-1:0] src;
    logic             fin;
    lz_out_t          tail;
    step_bytes.delete();
    if (s) begin
      ph_q     = PhCtrl;
      flags_q  = '0;
      tok_q    = '0;
      lens_q   = '0;
      base_q   = '0;
      left_q   = '0;
      off_lo_q = '0;
      cnt_q    = '0;
    end
    if (ph_q == PhDone) begin
      return;
    end
    if (size_q > BlockLimit || cnt_q >= size_q) begin
      ph_q = PhDone;
      return;
    end
    case (ph_q)
      PhCtrl: begin
        flags_q = d;
        tok_q   = '0;
        ph_q    = PhLen;
      end
      PhLen: begin
        lens_q = d;
        base_q = cnt_q;
        open_token();
      end
      PhLit: begin
        if (!store_byte(d)) begin
          left_q = left_q - LenW'(1);
          if (left_q == '0) begin
            close_token();
          end
        end
      end
      PhOffLo: begin
        off_lo_q = d;
        ph_q     = PhOffHi;
      end
      default: begin
        off = {d, off_lo_q};
        if (SizeW'(off) > base_q || base_q - SizeW'(off) >= cnt_q) begin
          tail = '{out_byte: '0, run_last: 1'b0, block_done: 1'b1, ref_error: 1'b1};
          step_bytes.push_back(tail);
          ph_q = PhDone;
        end else begin
          // copy forward one byte at a time so overlaps repeat
          src = base_q - SizeW'(off);
          fin = 1'b0;
          while (left_q != '0 && !fin) begin
            fin = store_byte(hist_mem[src % WinDepth]);
            src = src + SizeW'(1);
            left_q = left_q - LenW'(1);
          end
          if (!fin) begin
            close_token();
          end
        end
      end
    endcase
    if (step_bytes.size() > 0) begin
      tail = step_bytes.pop_back();
      tail.run_last = 1'b1;
      step_bytes.push_back(tail);
    end
  endfunction

  // Offer one compressed byte and predict what its transaction yields
  task automatic send_byte(input logic [ByteW-1:0] d, input logic s, input bit predict);
    int unsigned gap;
    @(negedge clk_i);
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       = 1'b1;
    in_bus.data_byte   = d;
    in_bus.block_start = s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    n_in++;
    decode_byte(d, s);
    if (predict) begin
      foreach (step_bytes[k]) decoded_q.push_back(step_bytes[k]);
    end
  endtask

  // Hold the input off until every awaited byte is out and the block is idle
  task automatic quiesce();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_out_size(input logic [SizeW-1:0] v);
    quiesce();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    size_q    = v;
    n_sizes++;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("timeout with %0d bytes still awaited", decoded_q.size());
    $display("status: fail");
    $finish;
  end

  // Output side: random stalls, then check each transaction in order
  initial begin : out_side
    int unsigned gap;
    lz_out_t     got;
    lz_out_t     want;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        out_bus.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      got.out_byte   = out_bus.out_byte;
      got.run_last   = out_bus.run_last;
      got.block_done = out_bus.block_done;
      got.ref_error  = out_bus.ref_error;
      n_out++;
      if (got.block_done === 1'b1) n_done++;
      if (got.ref_error === 1'b1) n_err++;
      if (decoded_q.size() == 0) begin
        mism++;
        if (mism <= MaxReport) begin
          $display("unexpected output byte %02h last %0b done %0b err %0b", got.out_byte,
                   got.run_last, got.block_done, got.ref_error);
        end
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.block_done !== want.block_done || got.ref_error !== want.ref_error) begin
          mism++;
          if (mism <= MaxReport) begin
            $display("output %0d: got byte %02h last %0b done %0b err %0b, want %02h %0b %0b %0b",
                     n_out, got.out_byte, got.run_last, got.block_done, got.ref_error,
                     want.out_byte, want.run_last, want.block_done, want.ref_error);
          end
        end
      end
    end
  end

  initial begin : in_side
    lz_out_t          typed_out;
    logic [SizeW-1:0] sz;
    logic [ByteW-1:0] flags;
    logic [ByteW-1:0] lens;
    int unsigned      r;
    int unsigned      rand_base;
    int unsigned      blk_items;
    int unsigned      blk_cap;
    int               gpos;
    int               pb;
    int               off;
    int               lo_ok;
    int               top;
    int               len_t;
    bit               ended;
    bit               first_ctrl;
    bit               paused;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.block_start = 1'b0;
    calm               = 1'b0;
    mism               = 0;
    n_in               = 0;
    n_out              = 0;
    n_done             = 0;
    n_err              = 0;
    n_sizes            = 0;
    ph_q               = PhCtrl;
    flags_q            = '0;
    tok_q              = '0;
    lens_q             = '0;
    base_q             = '0;
    left_q             = '0;
    off_lo_q           = '0;
    cnt_q              = '0;
    size_q             = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirTab[i]) begin
      if (DirTab[i].kind == RowCfg) begin
        write_out_size(DirTab[i].value);
      end else begin
        send_byte(DirTab[i].value[ByteW-1:0], DirTab[i].start, !DirTab[i].typed);
        if (DirTab[i].typed && DirTab[i].n_res) begin
          typed_out = '{out_byte: DirTab[i].e_byte, run_last: 1'b1,
                        block_done: DirTab[i].e_done, ref_error: DirTab[i].e_err};
          decoded_q.push_back(typed_out);
        end
      end
    end

    rand_base = n_in;
    paused    = 1'b0;
    while (n_in - rand_base < NumRand) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        sz = '0;
      end else if (r < 10) begin
        sz = SizeW'($urandom_range(BlockLimit + 1, (1 << SizeW) - 1));
      end else if (r < 14) begin
        sz = SizeW'(BlockLimit);
      end else if (r < 24) begin
        sz = SizeW'($urandom_range(61, 200));
      end else begin
        sz = SizeW'($urandom_range(1, 60));
      end
      calm = ($urandom_range(0, 3) == 0);
      write_out_size(sz);
      blk_cap    = (sz == '0 || sz > BlockLimit) ? 6 : 60;
      gpos       = 0;
      blk_items  = 0;
      ended      = 1'b0;
      first_ctrl = 1'b1;
      while (!ended) begin
        flags = ByteW'($urandom);
        send_byte(flags, first_ctrl, 1'b1);
        first_ctrl = 1'b0;
        blk_items++;
        for (int p = 0; p < 4 && !ended; p++) begin
          lens = ByteW'($urandom);
          send_byte(lens, 1'b0, 1'b1);
          blk_items++;
          pb = gpos;
          for (int t = 2 * p; t < 2 * p + 2 && !ended; t++) begin
            len_t = ((t % 2) ? int'(lens[3:0]) : int'(lens[7:4])) + 1;
            if (flags[7 - t]) begin
              // the first token of a pair cannot copy from its own start
              lo_ok = (t % 2 == 0) ? 1 : 0;
              if (pb >= lo_ok && $urandom_range(0, 9) < 8) begin
                top = (pb > lo_ok + 20 && $urandom_range(0, 2) != 0) ? lo_ok + 20 : pb;
                off = $urandom_range(lo_ok, top);
              end else begin
                ended = 1'b1;
                if (lo_ok == 1 && $urandom_range(0, 1) == 1) begin
                  off = 0;
                end else begin
                  off = $urandom_range(pb + 1, 65535);
                end
              end
              send_byte(off[7:0], 1'b0, 1'b1);
              send_byte(off[15:8], 1'b0, 1'b1);
              blk_items += 2;
              gpos += len_t;
            end else begin
              for (int k = 0; k < len_t; k++) begin
                send_byte(ByteW'($urandom), 1'b0, 1'b1);
                blk_items++;
                gpos++;
              end
            end
            // noise: a stray byte, now and then with a block start
            if ($urandom_range(0, 29) == 0) begin
              send_byte(ByteW'($urandom), ($urandom_range(0, 3) == 0), 1'b1);
              blk_items++;
            end
            if (!paused && n_in - rand_base >= NumRand / 2) begin
              paused = 1'b1;
              quiesce();
            end
            if (gpos >= int'(sz) || blk_items >= blk_cap || n_in - rand_base >= NumRand) begin
              ended = 1'b1;
            end
          end
        end
      end
      // now and then a trailing byte follows; it is dropped if the block is already done
      if ($urandom_range(0, 3) == 0) begin
        send_byte(ByteW'($urandom), 1'b0, 1'b1);
      end
    end

    quiesce();
    $display("covered %0d input transactions under %0d output sizes, %0d output bytes",
             n_in, n_sizes, n_out);
    $display("%0d block completions seen, %0d of them reference errors", n_done, n_err);
    if (mism == 0 && decoded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d bytes never arrived", mism, decoded_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: lz_block_decompressor.f
src/lzd_pkg.sv
src/lzd_if.sv
src/lz_block_decompressor.sv
tb/lz_block_decompressor_tb.sv
